[hdl/uvsf_pkg.sv]
package uvsf_pkg;

	localparam int MAX_SEGMENTS = 256;
	localparam int CORDIC_STEPS = 16;
	localparam int ATAN_N = 24;

	localparam logic [1:0] MODE_SOUTH = 2'd0;
	localparam logic [1:0] MODE_NORTH = 2'd1;
	localparam logic [1:0] MODE_SIDE  = 2'd2;

	localparam logic [2:0] REG_LON = 3'd0;
	localparam logic [2:0] REG_LAT = 3'd1;
	localparam logic [2:0] REG_RAD = 3'd2;
	localparam logic [2:0] REG_CX  = 3'd3;
	localparam logic [2:0] REG_CY  = 3'd4;
	localparam logic [2:0] REG_CZ  = 3'd5;

	typedef struct packed {
		logic [8:0]         lon;
		logic [8:0]         lat;
		logic [30:0]        radius;
		logic signed [31:0] cx;
		logic signed [31:0] cy;
		logic signed [31:0] cz;
	} cfg_t;

	typedef struct packed {
		logic       bad;
		logic [1:0] mode;
		logic [7:0] row;
		logic [7:0] col;
		logic [7:0] jn;
	} req_t;

	// atan(2^-i) as a fraction of a full turn, 2^32 = one turn
	function automatic logic [30:0] atan_turn(input logic [4:0] i);
		logic [30:0] r;
		case (i)
			5'd0:  r = 31'd536870912;
			5'd1:  r = 31'd316933406;
			5'd2:  r = 31'd167458907;
			5'd3:  r = 31'd85004756;
			5'd4:  r = 31'd42667331;
			5'd5:  r = 31'd21354465;
			5'd6:  r = 31'd10679838;
			5'd7:  r = 31'd5340245;
			5'd8:  r = 31'd2670163;
			5'd9:  r = 31'd1335087;
			5'd10: r = 31'd667544;
			5'd11: r = 31'd333772;
			5'd12: r = 31'd166886;
			5'd13: r = 31'd83443;
			5'd14: r = 31'd41722;
			5'd15: r = 31'd20861;
			5'd16: r = 31'd10430;
			5'd17: r = 31'd5215;
			5'd18: r = 31'd2608;
			5'd19: r = 31'd1304;
			5'd20: r = 31'd652;
			5'd21: r = 31'd326;
			5'd22: r = 31'd163;
			5'd23: r = 31'd81;
			default: r = 31'd0;
		endcase
		return r;
	endfunction

endpackage

[hdl/uvsf_front.sv]
module uvsf_front (
	input  logic          clk,
	input  logic          arst_n,
	input  uvsf_pkg::cfg_t cfg,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [1:0]    mode,
	input  logic [7:0]    ring_row,
	input  logic [7:0]    lon_column,
	output logic          req_valid,
	output uvsf_pkg::req_t req,
	input  logic          req_pop
);
	uvsf_pkg::req_t fifo_q [2];
	logic       wptr_q, rptr_q;
	logic [1:0] cnt_q;
	uvsf_pkg::req_t cls;
	logic [8:0] col_inc;
	logic       push;

	always_comb begin
		col_inc  = {1'b0, lon_column} + 9'd1;
		cls.mode = mode;
		cls.row  = ring_row;
		cls.col  = lon_column;
		cls.jn   = (col_inc == cfg.lon) ? 8'd0 : col_inc[7:0];
		cls.bad  = (mode == 2'd3) || (cfg.lon < 9'd3) || (cfg.lon > 9'(uvsf_pkg::MAX_SEGMENTS))
			|| (cfg.lat < 9'd1) || (cfg.lat > 9'(uvsf_pkg::MAX_SEGMENTS))
			|| ({1'b0, lon_column} >= cfg.lon)
			|| ((mode == uvsf_pkg::MODE_SIDE)
				&& ((cfg.lat < 9'd2) || ({2'b0, ring_row} + 10'd2 > {1'b0, cfg.lat})));
	end

	assign in_ready  = (cnt_q != 2'd2);
	assign push      = in_valid && in_ready;
	assign req_valid = (cnt_q != 2'd0);
	assign req       = fifo_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) fifo_q[wptr_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) wptr_q <= ~wptr_q;
			if (req_pop) rptr_q <= ~rptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, req_pop};
		end
	end
endmodule

[hdl/uvsf_div.sv]
// turn fraction: round(num * 2^32 / den), one quotient bit per cycle; needs num < den
module uvsf_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [9:0]  num,
	input  logic [9:0]  den,
	output logic [31:0] quot,
	output logic        done
);
	logic        busy_q, done_q;
	logic [4:0]  cnt_q;
	logic [9:0]  rem_q, den_q;
	logic [31:0] low_q, quot_q;
	logic [10:0] trial;
	logic        ge;

	assign trial = {rem_q, low_q[31]};
	assign ge    = trial >= {1'b0, den_q};
	assign quot  = quot_q;
	assign done  = done_q;

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			den_q <= den;
			low_q <= {23'd0, den[9:1]};
		end else if (busy_q) begin
			rem_q  <= ge ? 10'(trial - {1'b0, den_q}) : trial[9:0];
			low_q  <= {low_q[30:0], 1'b0};
			quot_q <= {quot_q[30:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end
endmodule

[hdl/uvsf_cordic.sv]
module uvsf_cordic (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [31:0]        ang,
	output logic signed [31:0] cos_o,
	output logic signed [31:0] sin_o,
	output logic               done
);
	localparam logic signed [33:0] ONE  = 34'sd1073741824;
	localparam logic signed [33:0] GAIN = 34'sd652032875;

	logic               busy_q, done_q, neg_q;
	logic [4:0]         cnt_q;
	logic signed [33:0] x_q, y_q, dx, dy, xf, yf;
	logic signed [32:0] z_q, at;
	logic [31:0]        a_fold;
	logic               fold;

	assign fold   = ((ang + 32'h4000_0000) & 32'h8000_0000) != 32'd0;
	assign a_fold = fold ? ang + 32'h8000_0000 : ang;
	assign dx     = y_q >>> cnt_q;
	assign dy     = x_q >>> cnt_q;
	assign at     = signed'({2'b00, uvsf_pkg::atan_turn(cnt_q)});
	assign xf     = neg_q ? -x_q : x_q;
	assign yf     = neg_q ? -y_q : y_q;
	assign cos_o  = (xf > ONE) ? 32'(ONE) : ((xf < -ONE) ? 32'(-ONE) : xf[31:0]);
	assign sin_o  = (yf > ONE) ? 32'(ONE) : ((yf < -ONE) ? 32'(-ONE) : yf[31:0]);
	assign done   = done_q;

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= GAIN;
			y_q   <= '0;
			z_q   <= signed'({a_fold[31], a_fold});
			neg_q <= fold;
		end else if (busy_q) begin
			if (!z_q[32]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(uvsf_pkg::CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end
endmodule

[hdl/uvsf_back.sv]
module uvsf_back (
	input  logic               clk,
	input  logic               arst_n,
	input  uvsf_pkg::cfg_t     cfg,
	input  logic               req_valid,
	input  uvsf_pkg::req_t     req,
	output logic               req_pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] vx, vy, vz,
	output logic signed [15:0] nx, ny, nz,
	output logic               out_bad,
	output logic               out_last
);
	localparam logic [2:0] B_IDLE  = 3'd0;
	localparam logic [2:0] B_SETUP = 3'd1;
	localparam logic [2:0] B_DIV   = 3'd2;
	localparam logic [2:0] B_COR   = 3'd3;
	localparam logic [2:0] B_MUL1  = 3'd4;
	localparam logic [2:0] B_MUL2  = 3'd5;
	localparam logic [2:0] B_FIN   = 3'd6;
	localparam logic signed [31:0] ONE = 32'sd1073741824;

	logic [2:0]     st_q;
	uvsf_pkg::req_t r_q;
	logic [2:0]     k_q;
	logic           side, north, pole, off, use_jn, last_k;
	logic [9:0]     th_num, th_den, ph_num;
	logic [31:0]    th_ang, ph_ang;
	logic           th_done, ph_done, d_start, c_start;
	logic           th_done_c, ph_done_c;
	logic signed [31:0] ct, stt, cp, sp;
	logic signed [63:0] pxs_q, pzs_q;
	logic signed [31:0] ct_q, u0_q, u1_q, u2_q;
	logic signed [63:0] rp0_q, rp1_q, rp2_q;
	logic signed [15:0] n0_q, n1_q, n2_q;
	logic signed [31:0] rad_s;
	logic           load;
	logic signed [31:0] p0, p1, p2;

	function automatic logic signed [31:0] rnd30(input logic signed [63:0] v);
		logic signed [63:0] t;
		t = (v + 64'sd536870912) >>> 30;
		return t[31:0];
	endfunction

	function automatic logic signed [31:0] place(input logic signed [31:0] c,
		input logic signed [63:0] rp);
		logic signed [32:0] s;
		s = 33'(c) + 33'(rnd30(rp));
		if (s > 33'sd2147483647) return 32'h7FFF_FFFF;
		if (s < -33'sd2147483648) return 32'h8000_0000;
		return s[31:0];
	endfunction

	function automatic logic signed [15:0] nrm(input logic signed [31:0] u, input logic inv);
		logic signed [32:0] v, t;
		v = inv ? -33'(u) : 33'(u);
		t = (v + 33'sd32768) >>> 16;
		if (t > 33'sd32767) return 16'h7FFF;
		if (t < -33'sd32768) return 16'h8000;
		return t[15:0];
	endfunction

	always_comb begin
		side   = (r_q.mode == uvsf_pkg::MODE_SIDE);
		north  = (r_q.mode == uvsf_pkg::MODE_NORTH);
		pole   = !side && (k_q == 3'd0);
		off    = side && (k_q == 3'd2 || k_q == 3'd3 || k_q == 3'd5);
		use_jn = side ? (k_q == 3'd0 || k_q == 3'd2 || k_q == 3'd3) : (k_q == 3'd2);
		last_k = r_q.bad || (side ? (k_q == 3'd5) : (k_q == 3'd2));
		th_num = side ? {2'b0, r_q.row} + 10'd1 + {9'd0, off} : 10'd1;
		th_den = {cfg.lat, 1'b0} + 10'd2;
		ph_num = {2'b0, use_jn ? r_q.jn : r_q.col};
		d_start = (st_q == B_SETUP) && !r_q.bad && !pole;
		c_start = (st_q == B_DIV) && th_done;
		rad_s  = signed'({1'b0, cfg.radius});
		load   = (st_q == B_FIN) && (!out_valid || out_ready);
		p0 = place(cfg.cx, rp0_q);
		p1 = place(cfg.cy, rp1_q);
		p2 = place(cfg.cz, rp2_q);
	end

	uvsf_div u_th_div (.clk, .arst_n, .start(d_start), .num(th_num), .den(th_den),
		.quot(th_ang), .done(th_done));
	uvsf_div u_ph_div (.clk, .arst_n, .start(d_start), .num(ph_num), .den({1'b0, cfg.lon}),
		.quot(ph_ang), .done(ph_done));
	uvsf_cordic u_th_cor (.clk, .arst_n, .start(c_start), .ang(th_ang),
		.cos_o(ct), .sin_o(stt), .done(th_done_c));
	uvsf_cordic u_ph_cor (.clk, .arst_n, .start(c_start), .ang(ph_ang),
		.cos_o(cp), .sin_o(sp), .done(ph_done_c));

	assign req_pop = (st_q == B_IDLE) && req_valid;

	always_ff @(posedge clk) begin
		if (req_pop) r_q <= req;
		case (st_q)
			B_SETUP: begin
				u0_q <= '0;
				u1_q <= north ? ONE : -ONE;
				u2_q <= '0;
			end
			B_COR: begin
				pxs_q <= stt * cp;
				pzs_q <= stt * sp;
				ct_q  <= ct;
			end
			B_MUL1: begin
				u0_q <= rnd30(pxs_q);
				u1_q <= north ? ct_q : -ct_q;
				u2_q <= rnd30(pzs_q);
			end
			B_MUL2: begin
				rp0_q <= rad_s * u0_q;
				rp1_q <= rad_s * u1_q;
				rp2_q <= rad_s * u2_q;
				n0_q  <= (cfg.radius == '0) ? '0 : nrm(u0_q, north);
				n1_q  <= (cfg.radius == '0) ? '0 : nrm(u1_q, north);
				n2_q  <= (cfg.radius == '0) ? '0 : nrm(u2_q, north);
			end
			default: ;
		endcase
		if (load) begin
			vx       <= r_q.bad ? '0 : p0;
			vy       <= r_q.bad ? '0 : p1;
			vz       <= r_q.bad ? '0 : p2;
			nx       <= r_q.bad ? '0 : n0_q;
			ny       <= r_q.bad ? '0 : n1_q;
			nz       <= r_q.bad ? '0 : n2_q;
			out_bad  <= r_q.bad;
			out_last <= last_k;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= B_IDLE;
			k_q       <= '0;
			out_valid <= 1'b0;
		end else begin
			if (load) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			case (st_q)
				B_IDLE:  if (req_valid) begin
					st_q <= B_SETUP;
					k_q  <= '0;
				end
				B_SETUP: st_q <= (r_q.bad || pole) ? B_MUL2 : B_DIV;
				B_DIV:   if (th_done && ph_done) st_q <= B_COR;
				B_COR:   if (th_done_c && ph_done_c) st_q <= B_MUL1;
				B_MUL1:  st_q <= B_MUL2;
				B_MUL2:  st_q <= B_FIN;
				B_FIN:   if (load) begin
					k_q  <= k_q + 3'd1;
					st_q <= last_k ? B_IDLE : B_SETUP;
				end
				default: st_q <= B_IDLE;
			endcase
		end
	end
endmodule

[hdl/uv_sphere_facet_generator.sv]
// Latitude/longitude sphere facet generator. A request (mode, ring row, column) is checked
// and queued by the front end (two entries deep), so new requests are taken while vertices
// are still being built. The back end builds one vertex at a time: two bit-serial dividers
// form the ring and column angles, two 16-step CORDICs give sine and cosine, and the MUL1,
// MUL2 and FIN states multiply, scale and offset. A cap request yields three vertices and a
// side request six; a rejected request gives a single flagged result. Pole vertices skip the
// angle units.
module uv_sphere_facet_generator (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [2:0]    cfg_index,
	input  logic [31:0]   cfg_data,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	input  logic [23:0]   s_axis_tdata,  // mode[1:0], ring_row[9:2], lon_column[17:10]
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	output logic [143:0]  m_axis_tdata,  // vert_x, vert_y, vert_z, norm_x, norm_y, norm_z
	output logic          m_axis_tuser,  // bad_request
	output logic          m_axis_tlast   // last_vertex
);
	uvsf_pkg::cfg_t cfg_q;
	uvsf_pkg::req_t req;
	logic           req_valid, req_pop;
	logic signed [31:0] vx, vy, vz;
	logic signed [15:0] nx, ny, nz;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lon    <= 9'd16;
			cfg_q.lat    <= 9'd8;
			cfg_q.radius <= 31'd65536;
			cfg_q.cx     <= '0;
			cfg_q.cy     <= '0;
			cfg_q.cz     <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				uvsf_pkg::REG_LON: cfg_q.lon    <= cfg_data[8:0];
				uvsf_pkg::REG_LAT: cfg_q.lat    <= cfg_data[8:0];
				uvsf_pkg::REG_RAD: cfg_q.radius <= cfg_data[30:0];
				uvsf_pkg::REG_CX:  cfg_q.cx     <= cfg_data;
				uvsf_pkg::REG_CY:  cfg_q.cy     <= cfg_data;
				uvsf_pkg::REG_CZ:  cfg_q.cz     <= cfg_data;
				default: ;
			endcase
		end
	end

	uvsf_front u_front (
		.clk, .arst_n, .cfg(cfg_q),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.mode(s_axis_tdata[1:0]), .ring_row(s_axis_tdata[9:2]),
		.lon_column(s_axis_tdata[17:10]),
		.req_valid, .req, .req_pop
	);

	uvsf_back u_back (
		.clk, .arst_n, .cfg(cfg_q), .req_valid, .req, .req_pop,
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.vx, .vy, .vz, .nx, .ny, .nz,
		.out_bad(m_axis_tuser), .out_last(m_axis_tlast)
	);

	assign m_axis_tdata = {nz, ny, nx, vz, vy, vx};

	a_bad_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
		else $error("rejected request result not marked last");

	a_bad_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 144'd0)
		else $error("rejected request result carries data");
endmodule
